FILE: rtl/chained_hash_table_unit_assert.svh
// Assertion macros for the chained hash table unit.
`ifndef CHAINED_HASH_TABLE_UNIT_ASSERT_SVH
`define CHAINED_HASH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CHT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("chained hash table: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("chained hash table: next-cycle check failed");

`endif

FILE: rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared constants, types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

	localparam int POOL_NODES     = 1024;
	localparam int MAX_BUCKETS    = 256;
	localparam int MAX_CHAIN_WALK = 1024;
	localparam int VALUE_WIDTH    = 32;
	localparam int KEY_W          = 32;
	localparam int NODE_W         = $clog2(POOL_NODES);
	localparam int LINK_W         = NODE_W + 1;
	localparam int BKT_W          = $clog2(MAX_BUCKETS);
	localparam int BC_W           = 9;
	localparam int CNT_W          = 11;
	localparam int CHK_W          = $clog2(MAX_CHAIN_WALK + 1);
	localparam int MOD_BPC        = 4;
	localparam int MOD_STEPS      = KEY_W / MOD_BPC;
	localparam int MOD_CNT_W      = $clog2(MOD_STEPS);

	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_NODES);

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_HEAD_RD,
		ST_DISPATCH,
		ST_WALK,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic head_rd;
		logic insert;
		logic walk_init;
		logic node_rd;
		logic hit;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic  mod_last;
		kind_t kind;
		logic  walk_end;
		logic  match;
	} stat_t;

endpackage

`default_nettype wire

FILE: rtl/chained_hash_table_unit.sv
// An insert or an unknown request goes from the bucket modulo through the head read to done;
// a lookup or remove then walks the chain, reading and comparing each node, until a hit or the end.
// Busy falls at the end of the done cycle; a new request is accepted only while busy is low.
// The bucket modulo takes 4 key bits a cycle, and each chain step reads a node, then compares its key.
// Results are valid with done and hold until the next request is loaded; the receiver cannot stall.
// Reset clears all bucket heads, empties the pool and sets bucket_count to 256 at once.
// ----------------------------------------------------------------------------
// chained_hash_table_unit
// Hash table with separate chaining over a fixed node pool: insert, lookup, remove.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chained_hash_table_unit_assert.svh"

module chained_hash_table_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    kind,
	input  logic [cht_pkg::KEY_W-1:0]     key,
	input  logic [cht_pkg::VALUE_WIDTH-1:0] value,
	input  logic                          cfg_we,
	input  logic [cht_pkg::BC_W-1:0]      cfg_wdata,
	output logic                          done,
	output logic                          found,
	output logic [cht_pkg::VALUE_WIDTH-1:0] found_value,
	output logic                          pool_full,
	output logic [cht_pkg::CNT_W-1:0]     entry_count
);
	import cht_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	cht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cht_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.key         (key),
		.value       (value),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.found       (found),
		.found_value (found_value),
		.pool_full   (pool_full),
		.entry_count (entry_count)
	);

	`CHT_ASSERT_NEXT(a_done_frees, done, !busy)
	`CHT_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done)
	`CHT_ASSERT_IMP(a_count_range, 1'b1, entry_count <= CNT_W'(POOL_NODES))
	`CHT_ASSERT_IMP(a_flags_excl, done, !(found && pool_full))

endmodule

`default_nettype wire

FILE: rtl/cht_ctrl.sv
// ----------------------------------------------------------------------------
// cht_ctrl
// Request sequencer: modulo, head fetch, insert or chain walk, result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cht_pkg::stat_t stat,
	output cht_pkg::cmd_t  cmd,
	output logic          busy,
	output logic          done
);
	import cht_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) state_d = ST_HEAD_RD;
			end
			ST_HEAD_RD: begin
				cmd.head_rd = 1'b1;
				state_d     = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (stat.kind)
					KIND_INSERT: begin
						cmd.insert = 1'b1;
						state_d    = ST_DONE;
					end
					KIND_LOOKUP, KIND_REMOVE: begin
						cmd.walk_init = 1'b1;
						state_d       = ST_WALK;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_WALK: begin
				if (stat.walk_end) begin
					state_d = ST_DONE;
				end else begin
					cmd.node_rd = 1'b1;
					state_d     = ST_CMP;
				end
			end
			ST_CMP: begin
				if (stat.match) begin
					cmd.hit = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_WALK;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

`default_nettype wire

FILE: rtl/cht_dpath.sv
// ----------------------------------------------------------------------------
// cht_dpath
// Bucket modulo, bucket head table, node pool, free stack and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cht_pkg::cmd_t                 cmd,
	output cht_pkg::stat_t                stat,
	input  logic [1:0]                    kind,
	input  logic [cht_pkg::KEY_W-1:0]     key,
	input  logic [cht_pkg::VALUE_WIDTH-1:0] value,
	input  logic                          cfg_we,
	input  logic [cht_pkg::BC_W-1:0]      cfg_wdata,
	output logic                          found,
	output logic [cht_pkg::VALUE_WIDTH-1:0] found_value,
	output logic                          pool_full,
	output logic [cht_pkg::CNT_W-1:0]     entry_count
);
	import cht_pkg::*;

	logic [BC_W-1:0]        bc_q;
	logic [BC_W-1:0]        eff_b;
	kind_t                  kind_q;
	logic [KEY_W-1:0]       key_q;
	logic [KEY_W-1:0]       shift_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [BC_W-1:0]        rem_q;
	logic [BC_W-1:0]        rem_d;
	logic [BC_W:0]          trial;
	logic [MOD_CNT_W-1:0]   mcnt_q;
	logic [BKT_W-1:0]       bucket;

	logic [MAX_BUCKETS-1:0] head_vld_q;
	logic [LINK_W-1:0]      head_mem [MAX_BUCKETS];
	logic [LINK_W-1:0]      head_rd_q;
	logic                   head_vld_rd_q;
	logic [LINK_W-1:0]      head_cur;

	logic [KEY_W-1:0]       nkey_mem  [POOL_NODES];
	logic [VALUE_WIDTH-1:0] nval_mem  [POOL_NODES];
	logic [LINK_W-1:0]      nnext_mem [POOL_NODES];
	logic [KEY_W-1:0]       nkey_rd_q;
	logic [VALUE_WIDTH-1:0] nval_rd_q;
	logic [LINK_W-1:0]      nnext_rd_q;

	logic [NODE_W-1:0]      fl_mem [POOL_NODES];
	logic [NODE_W-1:0]      fl_rd_q;
	logic                   fl_fresh_q;
	logic [CNT_W-1:0]       used_q;
	logic [CNT_W-1:0]       hw_q;
	logic [CNT_W-1:0]       pop_pos;
	logic [CNT_W-1:0]       push_pos;
	logic [NODE_W-1:0]      new_node;
	logic                   full_now;
	logic                   do_ins;
	logic                   do_rem;

	logic [LINK_W-1:0]      cur_q;
	logic [LINK_W-1:0]      prev_q;
	logic [CHK_W-1:0]       chk_q;
	logic                   found_q;
	logic [VALUE_WIDTH-1:0] fval_q;
	logic                   full_q;

	always_comb begin
		if (bc_q == '0) begin
			eff_b = BC_W'(1);
		end else if (bc_q > BC_W'(MAX_BUCKETS)) begin
			eff_b = BC_W'(MAX_BUCKETS);
		end else begin
			eff_b = bc_q;
		end
	end

	// Restoring remainder, several key bits per cycle, most significant first.
	always_comb begin
		rem_d = rem_q;
		trial = '0;
		for (int i = 0; i < MOD_BPC; i++) begin
			trial = {rem_d, shift_q[KEY_W-1-i]};
			if (trial >= {1'b0, eff_b}) trial = trial - {1'b0, eff_b};
			rem_d = trial[BC_W-1:0];
		end
	end

	assign bucket   = rem_q[BKT_W-1:0];
	assign head_cur = head_vld_rd_q ? head_rd_q : NIL_LINK;
	assign pop_pos  = CNT_W'(POOL_NODES - 1) - used_q;
	assign push_pos = CNT_W'(POOL_NODES) - used_q;
	assign new_node = fl_fresh_q ? pop_pos[NODE_W-1:0] : fl_rd_q;
	assign full_now = (used_q >= CNT_W'(POOL_NODES));
	assign do_ins   = cmd.insert && !full_now;
	assign do_rem   = cmd.hit && (kind_q == KIND_REMOVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q       <= BC_W'(MAX_BUCKETS);
			used_q     <= '0;
			hw_q       <= '0;
			head_vld_q <= '0;
		end else begin
			if (cfg_we) bc_q <= cfg_wdata;
			if (do_ins) begin
				used_q             <= used_q + CNT_W'(1);
				head_vld_q[bucket] <= 1'b1;
				if (used_q >= hw_q) hw_q <= used_q + CNT_W'(1);
			end else if (do_rem) begin
				if (used_q != '0) used_q <= used_q - CNT_W'(1);
				if (prev_q == NIL_LINK) head_vld_q[bucket] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind_t'(kind);
			key_q   <= key;
			shift_q <= key;
			val_q   <= value;
			rem_q   <= '0;
			mcnt_q  <= '0;
			found_q <= 1'b0;
			fval_q  <= '0;
			full_q  <= 1'b0;
		end
		if (cmd.mod_step) begin
			rem_q   <= rem_d;
			shift_q <= shift_q << MOD_BPC;
			mcnt_q  <= mcnt_q + MOD_CNT_W'(1);
		end
		if (cmd.head_rd) begin
			head_vld_rd_q <= head_vld_q[bucket];
			// Stack slots below the lowest depth ever reached were never written; their own index is used instead.
			fl_fresh_q    <= (used_q >= hw_q);
		end
		if (cmd.insert) full_q <= full_now;
		if (cmd.walk_init) begin
			cur_q  <= head_cur;
			prev_q <= NIL_LINK;
			chk_q  <= '0;
		end
		if (cmd.advance) begin
			prev_q <= cur_q;
			cur_q  <= nnext_rd_q;
			chk_q  <= chk_q + CHK_W'(1);
		end
		if (cmd.hit) begin
			found_q <= 1'b1;
			if (kind_q == KIND_LOOKUP) fval_q <= nval_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.head_rd) head_rd_q <= head_mem[bucket];
		if (do_ins) begin
			head_mem[bucket] <= {1'b0, new_node};
		end else if (do_rem && prev_q == NIL_LINK) begin
			head_mem[bucket] <= nnext_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.node_rd) begin
			nkey_rd_q  <= nkey_mem[cur_q[NODE_W-1:0]];
			nval_rd_q  <= nval_mem[cur_q[NODE_W-1:0]];
			nnext_rd_q <= nnext_mem[cur_q[NODE_W-1:0]];
		end
		if (do_ins) begin
			nkey_mem[new_node]  <= key_q;
			nval_mem[new_node]  <= val_q;
			nnext_mem[new_node] <= head_cur;
		end else if (do_rem && prev_q != NIL_LINK) begin
			nnext_mem[prev_q[NODE_W-1:0]] <= nnext_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.head_rd) fl_rd_q <= fl_mem[pop_pos[NODE_W-1:0]];
		if (do_rem && used_q != '0) fl_mem[push_pos[NODE_W-1:0]] <= cur_q[NODE_W-1:0];
	end

	assign stat.mod_last = (mcnt_q == MOD_CNT_W'(MOD_STEPS - 1));
	assign stat.kind     = kind_q;
	assign stat.walk_end = (cur_q == NIL_LINK) || (chk_q == CHK_W'(MAX_CHAIN_WALK));
	assign stat.match    = (nkey_rd_q == key_q);

	assign found       = found_q;
	assign found_value = fval_q;
	assign pool_full   = full_q;
	assign entry_count = used_q;

endmodule

`default_nettype wire
